FILE: sv/wsd_pkg.sv
// shared types and constants of the websocket frame deframer
`default_nettype none

package wsd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // one result item as it moves from the parser to the output stage
    typedef struct packed {
        logic       empty_frame;
        logic       frame_end;
        logic [3:0] frame_opcode;
        logic [7:0] payload_byte;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/wsd_parser.sv
// front end: header parsing, unmasking and result generation
`default_nettype none

module wsd_parser (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire  [7:0]       i_byte,
    output logic             o_ready,
    input  wire              i_queue_full,
    output logic             o_push,
    output wsd_pkg::t_result o_result
);

    typedef enum logic [5:0] {
        ST_HDR0 = 6'b000001,
        ST_HDR1 = 6'b000010,
        ST_EXT  = 6'b000100,
        ST_KEY  = 6'b001000,
        ST_DATA = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_mask, n_mask;
    logic [63:0] r_rem, n_rem;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_kidx, n_kidx;

    logic        take;
    logic [63:0] ext_len;
    logic [63:0] len_sel;
    logic        len_zero;
    logic [3:0]  cnt_dec;
    logic [7:0]  key_byte;
    logic [63:0] rem_dec;

    assign o_ready = !i_queue_full;
    assign take    = i_valid && o_ready;
    assign cnt_dec = r_cnt - 4'd1;
    assign ext_len = {r_rem[55:0], i_byte};
    assign rem_dec = r_rem - 64'd1;

    always_comb begin
        case (r_kidx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // length that a completed header carries, per state
    always_comb begin
        case (r_state)
            ST_HDR1: len_sel = {57'd0, i_byte[6:0]};
            ST_EXT:  len_sel = ext_len;
            default: len_sel = r_rem;
        endcase
    end
    assign len_zero = (len_sel == 64'd0);

    always_comb begin
        n_state  = r_state;
        n_opcode = r_opcode;
        n_mask   = r_mask;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_key    = r_key;
        n_kidx   = r_kidx;
        o_push   = 1'b0;
        o_result = '{empty_frame: 1'b1, frame_end: 1'b1,
                     frame_opcode: r_opcode, payload_byte: 8'd0};
        if (take) begin
            case (r_state)
                ST_HDR0: begin
                    n_opcode = i_byte[3:0];
                    n_state  = ST_HDR1;
                end
                ST_HDR1: begin
                    n_mask = i_byte[7];
                    if (i_byte[6:0] == wsd_pkg::LEN_EXT16 ||
                        i_byte[6:0] == wsd_pkg::LEN_EXT64) begin
                        n_cnt   = (i_byte[6:0] == wsd_pkg::LEN_EXT16) ?
                                  wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;
                        n_rem   = 64'd0;
                        n_state = ST_EXT;
                    end else begin
                        n_rem = len_sel;
                        if (i_byte[7]) begin
                            n_state = ST_KEY;
                            n_cnt   = wsd_pkg::KEY_BYTES;
                            n_key   = 32'd0;
                        end else begin
                            n_kidx = 2'd0;
                            if (len_zero) begin
                                o_push  = 1'b1;
                                n_state = (r_opcode == wsd_pkg::OP_CLOSE) ?
                                          ST_DONE : ST_HDR0;
                            end else begin
                                n_state = ST_DATA;
                            end
                        end
                    end
                end
                ST_EXT: begin
                    n_rem = ext_len;
                    n_cnt = cnt_dec;
                    if (cnt_dec == 4'd0) begin
                        if (r_mask) begin
                            n_state = ST_KEY;
                            n_cnt   = wsd_pkg::KEY_BYTES;
                            n_key   = 32'd0;
                        end else begin
                            n_kidx = 2'd0;
                            if (len_zero) begin
                                o_push  = 1'b1;
                                n_state = (r_opcode == wsd_pkg::OP_CLOSE) ?
                                          ST_DONE : ST_HDR0;
                            end else begin
                                n_state = ST_DATA;
                            end
                        end
                    end
                end
                ST_KEY: begin
                    n_key = {r_key[23:0], i_byte};
                    n_cnt = cnt_dec;
                    if (cnt_dec == 4'd0) begin
                        n_kidx = 2'd0;
                        if (len_zero) begin
                            o_push  = 1'b1;
                            n_state = (r_opcode == wsd_pkg::OP_CLOSE) ?
                                      ST_DONE : ST_HDR0;
                        end else begin
                            n_state = ST_DATA;
                        end
                    end
                end
                ST_DATA: begin
                    n_kidx = r_kidx + 2'd1;
                    n_rem  = rem_dec;
                    o_push = 1'b1;
                    o_result.empty_frame  = 1'b0;
                    o_result.frame_end    = (rem_dec == 64'd0);
                    o_result.payload_byte = r_mask ? (i_byte ^ key_byte) : i_byte;
                    if (rem_dec == 64'd0) begin
                        n_state = (r_opcode == wsd_pkg::OP_CLOSE) ? ST_DONE : ST_HDR0;
                    end
                end
                ST_DONE: begin
                    n_state = ST_DONE;
                end
                default: begin
                    n_state = ST_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_HDR0;
            r_opcode <= 4'd0;
            r_mask   <= 1'b0;
            r_rem    <= 64'd0;
            r_cnt    <= 4'd0;
            r_key    <= 32'd0;
            r_kidx   <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_rem    <= n_rem;
            r_cnt    <= n_cnt;
            r_key    <= n_key;
            r_kidx   <= n_kidx;
        end
    end

endmodule

`default_nettype wire

FILE: sv/wsd_queue.sv
// short result queue between parser and output stage
`default_nettype none

module wsd_queue #(
    parameter int DEPTH = wsd_pkg::QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wsd_pkg::t_result i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output wsd_pkg::t_result o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wsd_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: sv/wsd_out_stage.sv
// back end: output register driving the master stream
`default_nettype none

module wsd_out_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wsd_pkg::t_result i_data,
    output logic             o_pop,
    output logic             o_valid,
    output wsd_pkg::t_result o_data,
    input  wire              i_ready
);

    logic             r_valid, n_valid;
    wsd_pkg::t_result r_data;

    // refill whenever the register is empty or being drained this cycle
    assign o_pop   = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

FILE: sv/websocket_frame_deframer.sv
// websocket frame deframer top level: parser, result queue and output register
//
// usage: received stream bytes enter on the slave stream, one byte per
// transaction in s_axis_tdata. the parser walks the frame header (opcode
// byte, mask flag and 7-bit length, optional 16- or 64-bit big-endian
// extended length, optional 4-byte mask key) and then passes each payload
// byte, unmasked, to the master stream with the frame opcode and flags.
// header bytes produce no transaction, except that the byte closing the
// header of a zero-length frame produces one empty-frame marker.
// throughput: one byte per cycle while the queue is not full; the parser
// settles each byte in the cycle it is taken, the 64-bit length countdown
// being its longest path. a taken payload byte is written into the queue
// and then moved into the output register that drives m_axis.
// stall: the queue of QUEUE_DEPTH entries absorbs receiver backpressure;
// s_axis_tready drops only once it is full, and rises again as it drains.
// reset: synchronous active low, returns the parser to the first header byte
// and empties the queue and output register. after a close frame ends, all
// further bytes are taken and dropped until the next reset.
`default_nettype none

module websocket_frame_deframer #(
    parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // received byte stream
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [7:0] rx_byte
    // deframed payload stream
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic       m_axis_tlast,   // frame_end
    output logic [4:0] m_axis_tuser    // [3:0] frame_opcode, [4] empty_frame
);

    wsd_pkg::t_result push_data;
    wsd_pkg::t_result queue_data;
    wsd_pkg::t_result out_data;
    logic             push;
    logic             queue_full;
    logic             queue_valid;
    logic             pop;

    // front: classifies each byte and builds result transactions
    wsd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_byte       (s_axis_tdata),
        .o_ready      (s_axis_tready),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_result     (push_data)
    );

    // decouples the parser from receiver stalls
    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_data  (queue_data)
    );

    // back: registered master stream
    wsd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_data  (queue_data),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_data  (out_data),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = out_data.payload_byte;
    assign m_axis_tlast = out_data.frame_end;
    assign m_axis_tuser = {out_data.empty_frame, out_data.frame_opcode};

endmodule

`default_nettype wire

FILE: tb/websocket_frame_deframer_tb.sv
// self-checking testbench for the websocket frame deframer: directed table, random frames
`timescale 1ns / 100ps

module websocket_frame_deframer_tb;

    localparam real CLK_PERIOD   = 12.0;
    localparam int  ITEM_TARGET  = 950;
    localparam int  DRAIN_CYCLES = 20;
    localparam int  LONG_HOLD    = 80;
    localparam int  TIMEOUT_NS   = 3_000_000;

    // parser position inside the frame
    typedef enum logic [2:0] {
        ST_HEADER,
        ST_LENGTH,
        ST_EXTLEN,
        ST_KEY,
        ST_PAYLOAD,
        ST_CLOSED
    } t_parse_state;

    // receiver behavior over one stretch of cycles
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } t_rx_mode;

    // one row of the directed table: byte to send and, where typed, its result
    typedef struct packed {
        logic [7:0]       rx;
        logic             typed;
        wsd_pkg::t_result want;
    } t_stim_row;

    localparam int N_DIRECTED = 29;

    // typed results are written {empty_frame, frame_end, frame_opcode, payload_byte}
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        // empty text frame, fin set, no mask: marker on the length byte
        '{8'h81, 1'b0, '0},
        '{8'h00, 1'b1, {1'b1, 1'b1, 4'h1, 8'h00}},
        // binary frame with reserved bits set, one all-ones payload byte
        '{8'h72, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'hFF, 1'b1, {1'b0, 1'b1, 4'h2, 8'hFF}},
        // unknown opcode, masked, 16-bit length of zero: marker on last key byte
        '{8'h0F, 1'b0, '0},
        '{8'hFE, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h11, 1'b0, '0},
        '{8'h22, 1'b0, '0},
        '{8'h33, 1'b0, '0},
        '{8'h44, 1'b1, {1'b1, 1'b1, 4'hF, 8'h00}},
        // continuation opcode, masked, 64-bit length of two
        '{8'h80, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'hA5, 1'b0, '0},
        '{8'h5A, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] rx_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [7:0] payload_byte
    logic       m_axis_tlast;    // frame_end
    logic [4:0] m_axis_tuser;    // [3:0] frame_opcode, [4] empty_frame

    // deframer state as predicted from the accepted byte stream
    t_parse_state cur_state   = ST_HEADER;
    logic [3:0]   cur_opcode  = '0;
    logic         cur_masked  = 1'b0;
    logic [63:0]  bytes_left  = '0;
    logic [3:0]   field_left  = '0;
    logic [31:0]  key_word    = '0;
    logic [1:0]   key_idx     = '0;

    wsd_pkg::t_result pending_payload [$];
    int               mismatch_count = 0;
    int               results_seen   = 0;
    int               bytes_sent     = 0;
    int               burst_left     = 0;
    bit               steady         = 1'b0;

    websocket_frame_deframer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // a close frame locks the parser until reset
    function automatic void end_of_frame();
        cur_state = (cur_opcode == wsd_pkg::OP_CLOSE) ? ST_CLOSED : ST_HEADER;
    endfunction

    // header finished: either payload follows or the frame is empty
    function automatic bit header_complete(output wsd_pkg::t_result r);
        key_idx = '0;
        if (bytes_left == 0) begin
            r = '{empty_frame: 1'b1, frame_end: 1'b1, frame_opcode: cur_opcode,
                  payload_byte: 8'h00};
            end_of_frame();
            return 1'b1;
        end
        cur_state = ST_PAYLOAD;
        return 1'b0;
    endfunction

    // length settled: the mask key comes next if the mask flag was set
    function automatic bit length_known(output wsd_pkg::t_result r);
        r = '0;
        if (cur_masked) begin
            cur_state  = ST_KEY;
            field_left = wsd_pkg::KEY_BYTES;
            key_word   = '0;
            return 1'b0;
        end
        return header_complete(r);
    endfunction

    // advance the parser by one received byte; returns 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b, output wsd_pkg::t_result r);
        logic [6:0] len7;
        logic [7:0] key_byte;
        bit         fired;
        fired = 1'b0;
        r     = '0;
        case (cur_state)
            ST_HEADER: begin
                cur_opcode = b[3:0];
                cur_state  = ST_LENGTH;
            end
            ST_LENGTH: begin
                cur_masked = b[7];
                len7       = b[6:0];
                if (len7 == wsd_pkg::LEN_EXT16 || len7 == wsd_pkg::LEN_EXT64) begin
                    field_left = (len7 == wsd_pkg::LEN_EXT16) ?
                                 wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;
                    bytes_left = '0;
                    cur_state  = ST_EXTLEN;
                end else begin
                    bytes_left = 64'(len7);
                    fired      = length_known(r);
                end
            end
            ST_EXTLEN: begin
                bytes_left = {bytes_left[55:0], b};
                field_left = field_left - 4'd1;
                if (field_left == 0) fired = length_known(r);
            end
            ST_KEY: begin
                key_word   = {key_word[23:0], b};
                field_left = field_left - 4'd1;
                if (field_left == 0) fired = header_complete(r);
            end
            ST_PAYLOAD: begin
                key_byte   = cur_masked ? key_word[8 * (3 - key_idx) +: 8] : 8'h00;
                key_idx    = key_idx + 2'd1;
                bytes_left = bytes_left - 64'd1;
                r = '{empty_frame: 1'b0, frame_end: (bytes_left == 0),
                      frame_opcode: cur_opcode, payload_byte: b ^ key_byte};
                fired = 1'b1;
                if (bytes_left == 0) end_of_frame();
            end
            default: ;
        endcase
        return fired;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // compare every output transaction with the oldest predicted result
    always @(posedge i_clk) begin : check_output
        wsd_pkg::t_result want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            results_seen++;
            if (pending_payload.size() == 0) begin
                flag_mismatch($sformatf("unexpected transaction data %h last %b user %h",
                                        m_axis_tdata, m_axis_tlast, m_axis_tuser));
            end else begin
                want = pending_payload.pop_front();
                if (m_axis_tdata !== want.payload_byte)
                    flag_mismatch($sformatf("payload_byte %h, want %h",
                                            m_axis_tdata, want.payload_byte));
                if (m_axis_tuser[3:0] !== want.frame_opcode)
                    flag_mismatch($sformatf("frame_opcode %h, want %h",
                                            m_axis_tuser[3:0], want.frame_opcode));
                if (m_axis_tlast !== want.frame_end)
                    flag_mismatch($sformatf("frame_end %b, want %b",
                                            m_axis_tlast, want.frame_end));
                if (m_axis_tuser[4] !== want.empty_frame)
                    flag_mismatch($sformatf("empty_frame %b, want %b",
                                            m_axis_tuser[4], want.empty_frame));
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // offer one byte in bursts with random gaps; predict once it is taken
    task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input wsd_pkg::t_result want = '0);
        int               gap;
        bit               fired;
        wsd_pkg::t_result got;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        bytes_sent++;
        fired = deframe_byte(b, got);
        if (typed) pending_payload = {pending_payload, want};
        else if (fired) pending_payload = {pending_payload, got};
    endtask

    // one well-formed frame: random header flags, length encoding, mask and payload
    task automatic send_frame(input logic [3:0] op);
        logic [63:0] len;
        logic [31:0] key;
        bit          masked;
        int          pick;
        int          k;
        masked = 1'($urandom_range(0, 1));
        key    = $urandom;
        pick   = $urandom_range(0, 99);
        push_byte({4'($urandom_range(0, 15)), op});
        if (pick < 60) begin
            len = 64'($urandom_range(0, 12));
            push_byte({masked, len[6:0]});
        end else if (pick < 70) begin
            // up to the largest 7-bit length
            len = 64'($urandom_range(13, 125));
            push_byte({masked, len[6:0]});
        end else if (pick < 88) begin
            // 16-bit length, zero included, sometimes past one byte
            if ($urandom_range(0, 4) == 0) len = 64'($urandom_range(256, 300));
            else len = 64'($urandom_range(0, 40));
            push_byte({masked, wsd_pkg::LEN_EXT16});
            push_byte(len[15:8]);
            push_byte(len[7:0]);
        end else begin
            len = 64'($urandom_range(0, 24));
            push_byte({masked, wsd_pkg::LEN_EXT64});
            for (k = 7; k >= 0; k--) push_byte(len[8 * k +: 8]);
        end
        if (masked) for (k = 3; k >= 0; k--) push_byte(key[8 * k +: 8]);
        for (k = 0; k < len; k++) push_byte(8'($urandom));
    endtask

    initial begin : stimulus
        int         i;
        logic [3:0] op;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++)
            push_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        // random frames; a close frame would end parsing, so it is saved for last
        while (bytes_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) steady = !steady;
            op = 4'($urandom_range(0, 15));
            if (op == wsd_pkg::OP_CLOSE) op = 4'h1;
            send_frame(op);
        end

        // close frame, then bytes the block must take and drop
        send_frame(wsd_pkg::OP_CLOSE);
        repeat (12) push_byte(8'($urandom));
        s_axis_tvalid <= 1'b0;

        while (pending_payload.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // receiver: stretches of open, random, patterned and sparse tready, with
    // long hold-offs that fill the queue so that s_axis_tready must drop
    initial begin : receiver
        t_rx_mode mode;
        int       span;
        int       tick;
        int       hold_at;
        hold_at = 150;
        m_axis_tready <= 1'b0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(4, 60);
            if (results_seen >= hold_at) begin
                hold_at += 350;
                repeat (LONG_HOLD) begin
                    @(posedge i_clk);
                    m_axis_tready <= 1'b0;
                end
            end
            for (tick = 0; tick < span; tick++) begin
                @(posedge i_clk);
                case (mode)
                    RX_OPEN:    m_axis_tready <= 1'b1;
                    RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: m_axis_tready <= (tick % 4) != 3;
                    default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
sv/wsd_pkg.sv
sv/wsd_parser.sv
sv/wsd_queue.sv
sv/wsd_out_stage.sv
sv/websocket_frame_deframer.sv
tb/websocket_frame_deframer_tb.sv
